@@ src/rob_pkg.sv @@
// shared types and constants for the rgba over-blend pipeline
`default_nettype none

package rob_pkg;

    // full-scale channel value
    localparam int unsigned FULL = 255;

    localparam int CH_W   = 8;                 // one colour or alpha channel
    localparam int PROD_W = 2 * CH_W;          // 8x8 products and the divisor
    localparam int REM_W  = 3 * CH_W;          // divider remainder
    localparam int NUM_W  = REM_W + 1;         // blend numerator
    localparam int N_CH   = 3;                 // red, green, blue
    localparam int QUO_W  = CH_W;              // quotient bits below saturation

    // register stages: arithmetic front end, one per quotient bit, output
    localparam int PREP_STAGES = 4;
    localparam int N_STAGES    = PREP_STAGES + QUO_W + 1;

    typedef struct packed {
        logic [CH_W-1:0] top_red;
        logic [CH_W-1:0] top_green;
        logic [CH_W-1:0] top_blue;
        logic [CH_W-1:0] top_alpha;
        logic [CH_W-1:0] bottom_red;
        logic [CH_W-1:0] bottom_green;
        logic [CH_W-1:0] bottom_blue;
        logic [CH_W-1:0] bottom_alpha;
        logic            write_down;
    } t_rob_in;

    typedef struct packed {
        logic [CH_W-1:0] out_top_red;
        logic [CH_W-1:0] out_top_green;
        logic [CH_W-1:0] out_top_blue;
        logic [CH_W-1:0] out_top_alpha;
        logic [CH_W-1:0] out_bottom_red;
        logic [CH_W-1:0] out_bottom_green;
        logic [CH_W-1:0] out_bottom_blue;
        logic [CH_W-1:0] out_bottom_alpha;
    } t_rob_out;

    typedef enum logic [1:0] {
        MODE_PASS      = 2'd0,
        MODE_COPY_DOWN = 2'd1,
        MODE_COPY_UP   = 2'd2,
        MODE_BLEND     = 2'd3
    } t_rob_mode;

    typedef struct packed {
        t_rob_in   pix;
        t_rob_mode mode;
    } t_rob_ctl;

    // state of one item inside the divider stages
    typedef struct packed {
        t_rob_ctl                         ctl;
        logic [CH_W-1:0]                  alpha;
        logic [PROD_W-1:0]                den;
        logic [N_CH-1:0]                  sat;
        logic [N_CH-1:0][REM_W-1:0]       rem;
        logic [N_CH-1:0][QUO_W-1:0]       quo;
    } t_rob_div;

endpackage

`default_nettype wire

@@ src/rob_prep.sv @@
// front end: case decode, products, result alpha, numerators and divisor
`default_nettype none

module rob_prep (
    input  wire logic                              i_clk,
    input  wire logic [rob_pkg::PREP_STAGES-1:0]   i_en,
    input  wire rob_pkg::t_rob_in                  i_data,
    output rob_pkg::t_rob_div                      o_div
);

    localparam int CH_W   = rob_pkg::CH_W;
    localparam int PROD_W = rob_pkg::PROD_W;
    localparam int REM_W  = rob_pkg::REM_W;
    localparam int NUM_W  = rob_pkg::NUM_W;
    localparam int N_CH   = rob_pkg::N_CH;

    // stage 0: decode and 8x8 products
    logic [CH_W-1:0]              ta;
    logic [CH_W-1:0]              ba;
    logic [CH_W-1:0]              inv;
    logic [N_CH-1:0][CH_W-1:0]    tc;
    rob_pkg::t_rob_ctl            n_ctl0;
    logic [PROD_W-1:0]            n_p0;
    logic [N_CH-1:0][PROD_W-1:0]  n_tcta0;

    rob_pkg::t_rob_ctl            r_ctl0;
    logic [PROD_W-1:0]            r_p0;
    logic [N_CH-1:0][PROD_W-1:0]  r_tcta0;

    assign ta  = i_data.top_alpha;
    assign ba  = i_data.bottom_alpha;
    assign inv = CH_W'(rob_pkg::FULL) - ta;
    assign tc  = {i_data.top_blue, i_data.top_green, i_data.top_red};

    always_comb begin
        n_ctl0.pix = i_data;
        if (ta == CH_W'(rob_pkg::FULL) || ba == '0) begin
            n_ctl0.mode = (i_data.write_down && ta != '0) ? rob_pkg::MODE_COPY_DOWN
                                                          : rob_pkg::MODE_PASS;
        end else if (ta == '0) begin
            n_ctl0.mode = !i_data.write_down ? rob_pkg::MODE_COPY_UP
                                             : rob_pkg::MODE_PASS;
        end else begin
            n_ctl0.mode = rob_pkg::MODE_BLEND;
        end
        n_p0 = PROD_W'(ba) * PROD_W'(inv);
        for (int c = 0; c < N_CH; c++) begin
            n_tcta0[c] = PROD_W'(tc[c]) * PROD_W'(ta);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ctl0  <= n_ctl0;
            r_p0    <= n_p0;
            r_tcta0 <= n_tcta0;
        end
    end

    // stage 1: quotient estimate of p/255, bottom products, top terms times 255
    logic [PROD_W-1:0]            p_sum;
    logic [N_CH-1:0][CH_W-1:0]    bc1;
    logic [CH_W-1:0]              n_qe1;
    logic [N_CH-1:0][REM_W-1:0]   n_bcp1;
    logic [N_CH-1:0][REM_W-1:0]   n_t2551;

    rob_pkg::t_rob_ctl            r_ctl1;
    logic [PROD_W-1:0]            r_p1;
    logic [CH_W-1:0]              r_qe1;
    logic [N_CH-1:0][REM_W-1:0]   r_bcp1;
    logic [N_CH-1:0][REM_W-1:0]   r_t2551;

    assign p_sum = r_p0 + {{CH_W{1'b0}}, r_p0[PROD_W-1:CH_W]};
    assign n_qe1 = p_sum[PROD_W-1:CH_W];
    assign bc1   = {r_ctl0.pix.bottom_blue, r_ctl0.pix.bottom_green,
                    r_ctl0.pix.bottom_red};

    always_comb begin
        for (int c = 0; c < N_CH; c++) begin
            n_bcp1[c]  = REM_W'(bc1[c]) * REM_W'(r_p0);
            n_t2551[c] = {r_tcta0[c], {CH_W{1'b0}}}
                       - {{CH_W{1'b0}}, r_tcta0[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_ctl1  <= r_ctl0;
            r_p1    <= r_p0;
            r_qe1   <= n_qe1;
            r_bcp1  <= n_bcp1;
            r_t2551 <= n_t2551;
        end
    end

    // stage 2: correct the estimate into alpha, sum the numerators
    logic [PROD_W-1:0]            qe255;
    logic [PROD_W-1:0]            rm;
    logic [1:0]                   corr;
    logic [CH_W-1:0]              n_a2;
    logic [N_CH-1:0][NUM_W-1:0]   n_num2;

    rob_pkg::t_rob_ctl            r_ctl2;
    logic [CH_W-1:0]              r_a2;
    logic [N_CH-1:0][NUM_W-1:0]   r_num2;

    assign qe255 = {r_qe1, {CH_W{1'b0}}} - {{CH_W{1'b0}}, r_qe1};
    assign rm    = r_p1 - qe255;

    always_comb begin
        if (rm >= PROD_W'(2 * rob_pkg::FULL)) begin
            corr = 2'd2;
        end else if (rm >= PROD_W'(rob_pkg::FULL)) begin
            corr = 2'd1;
        end else begin
            corr = 2'd0;
        end
        n_a2 = r_ctl1.pix.top_alpha + r_qe1 + CH_W'(corr);
        for (int c = 0; c < N_CH; c++) begin
            n_num2[c] = NUM_W'(r_t2551[c]) + NUM_W'(r_bcp1[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_ctl2 <= r_ctl1;
            r_a2   <= n_a2;
            r_num2 <= n_num2;
        end
    end

    // stage 3: divisor 255*alpha, saturation check against divisor*256
    logic [PROD_W-1:0]  den3;
    rob_pkg::t_rob_div  n_div3;
    rob_pkg::t_rob_div  r_div3;

    assign den3 = {r_a2, {CH_W{1'b0}}} - {{CH_W{1'b0}}, r_a2};

    always_comb begin
        n_div3.ctl   = r_ctl2;
        n_div3.alpha = r_a2;
        n_div3.den   = den3;
        n_div3.quo   = '0;
        for (int c = 0; c < N_CH; c++) begin
            n_div3.sat[c] = r_num2[c] >= {1'b0, den3, {CH_W{1'b0}}};
            n_div3.rem[c] = r_num2[c][REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_div3 <= n_div3;
        end
    end

    assign o_div = r_div3;

endmodule

`default_nettype wire

@@ src/rob_div_stage.sv @@
// one restoring division step for the three colour channels
`default_nettype none

module rob_div_stage #(
    parameter int SHIFT = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire rob_pkg::t_rob_div  i_div,
    output rob_pkg::t_rob_div       o_div
);

    localparam int REM_W  = rob_pkg::REM_W;
    localparam int PROD_W = rob_pkg::PROD_W;

    logic [REM_W-1:0]   dsh;
    rob_pkg::t_rob_div  n_div;
    rob_pkg::t_rob_div  r_div;

    assign dsh = {{(REM_W - PROD_W){1'b0}}, i_div.den} << SHIFT;

    always_comb begin
        n_div = i_div;
        for (int c = 0; c < rob_pkg::N_CH; c++) begin
            if (i_div.rem[c] >= dsh) begin
                n_div.rem[c]        = i_div.rem[c] - dsh;
                n_div.quo[c][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

@@ src/rob_merge.sv @@
// output stage: picks pass, copy or blend result into the registered item
`default_nettype none

module rob_merge (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire rob_pkg::t_rob_div  i_div,
    output rob_pkg::t_rob_out       o_data
);

    localparam int CH_W = rob_pkg::CH_W;

    rob_pkg::t_rob_in               pix;
    logic [2:0][CH_W-1:0]           rgb;
    rob_pkg::t_rob_out              n_data;
    rob_pkg::t_rob_out              r_data;

    assign pix = i_div.ctl.pix;

    always_comb begin
        for (int c = 0; c < rob_pkg::N_CH; c++) begin
            rgb[c] = i_div.sat[c] ? CH_W'(rob_pkg::FULL) : i_div.quo[c];
        end
    end

    always_comb begin
        n_data.out_top_red      = pix.top_red;
        n_data.out_top_green    = pix.top_green;
        n_data.out_top_blue     = pix.top_blue;
        n_data.out_top_alpha    = pix.top_alpha;
        n_data.out_bottom_red   = pix.bottom_red;
        n_data.out_bottom_green = pix.bottom_green;
        n_data.out_bottom_blue  = pix.bottom_blue;
        n_data.out_bottom_alpha = pix.bottom_alpha;
        case (i_div.ctl.mode)
            rob_pkg::MODE_COPY_DOWN: begin
                n_data.out_bottom_red   = pix.top_red;
                n_data.out_bottom_green = pix.top_green;
                n_data.out_bottom_blue  = pix.top_blue;
                n_data.out_bottom_alpha = pix.top_alpha;
            end
            rob_pkg::MODE_COPY_UP: begin
                n_data.out_top_red   = pix.bottom_red;
                n_data.out_top_green = pix.bottom_green;
                n_data.out_top_blue  = pix.bottom_blue;
                n_data.out_top_alpha = pix.bottom_alpha;
            end
            rob_pkg::MODE_BLEND: begin
                if (pix.write_down) begin
                    n_data.out_bottom_red   = rgb[0];
                    n_data.out_bottom_green = rgb[1];
                    n_data.out_bottom_blue  = rgb[2];
                    n_data.out_bottom_alpha = i_div.alpha;
                end else begin
                    n_data.out_top_red   = rgb[0];
                    n_data.out_top_green = rgb[1];
                    n_data.out_top_blue  = rgb[2];
                    n_data.out_top_alpha = i_div.alpha;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

@@ src/rgba_over_blend.sv @@
// top level of the rgba8 over-composite pipeline
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------------
//  in      | i_in_valid  | o_in_stall  | i_in_data  (t_rob_in pixel pair)
//  out     | o_out_valid | i_out_stall | o_out_data (t_rob_out pixel pair)
//
// one item enters per clock while o_in_stall is low; 13 register stages, so o_out_valid
// rises once the accepted item has passed through every stage, and it leaves when i_out_stall is low
// depth is set by the restoring divider for 255*alpha: one quotient bit per stage
// i_rst_n (synchronous, active low) clears only the stage valid bits
// a stage moves when it is empty or the one after it moves, so bubbles close up
// and new items are taken while the output item waits on i_out_stall, until every stage is full
`default_nettype none

module rgba_over_blend (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rob_pkg::t_rob_in   i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rob_pkg::t_rob_out       o_out_data
);

    localparam int N_STAGES    = rob_pkg::N_STAGES;
    localparam int PREP_STAGES = rob_pkg::PREP_STAGES;
    localparam int QUO_W       = rob_pkg::QUO_W;

    // per-stage valid bits and move enables
    logic [N_STAGES-1:0]    r_vld;
    logic [N_STAGES-1:0]    n_vld;
    logic [N_STAGES-1:0]    adv;

    always_comb begin
        adv[N_STAGES-1] = !r_vld[N_STAGES-1] || !i_out_stall;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (adv[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < N_STAGES; k++) begin
            if (adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall  = !adv[0];
    assign o_out_valid = r_vld[N_STAGES-1];

    // datapath: front end, divider chain, output select
    rob_pkg::t_rob_div  div_chain [QUO_W+1];

    rob_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (adv[PREP_STAGES-1:0]),
        .i_data (i_in_data),
        .o_div  (div_chain[0])
    );

    // quotient bits from msb down, one stage each
    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        rob_div_stage #(
            .SHIFT (QUO_W - 1 - g)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (adv[PREP_STAGES+g]),
            .i_div (div_chain[g]),
            .o_div (div_chain[g+1])
        );
    end

    rob_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (adv[N_STAGES-1]),
        .i_div  (div_chain[QUO_W]),
        .o_data (o_out_data)
    );

endmodule

`default_nettype wire
